>>> rtl/u8v_pkg.sv
// Shared types, status codes and helper functions for the UTF-8 validator.
`default_nettype none

package u8v_pkg;

   // Sticky status codes reported on every result
   localparam logic [1:0] ST_NONE      = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_CONTROL   = 2'd2;

   // Minimum legal value classes of an open sequence
   localparam logic [1:0] CLASS_TWO   = 2'd0;
   localparam logic [1:0] CLASS_THREE = 2'd1;
   localparam logic [1:0] CLASS_FOUR  = 2'd2;

   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [20:0] SURR_LO     = 21'h00D800;
   localparam logic [20:0] SURR_HI     = 21'h00DFFF;

   // Decoder state carried from byte to byte
   typedef struct packed {
      logic [1:0]  bytes_pending;
      logic [20:0] partial_point;
      logic [1:0]  min_point_class;
      logic [1:0]  first_error;
   } seq_state_type;

   localparam seq_state_type SEQ_RESET = '{
      bytes_pending:   2'd0,
      partial_point:   21'd0,
      min_point_class: CLASS_TWO,
      first_error:     ST_NONE
   };

   // One result item
   typedef struct packed {
      logic [20:0] cp_value;
      logic        point_ready;
      logic [1:0]  status;
      logic        string_done;
   } rsp_type;

   // Smallest code point that an open sequence of this class may encode
   function automatic logic [20:0] min_point(input logic [1:0] cls);
      logic [20:0] v;
      case (cls)
         CLASS_TWO:   v = 21'h000080;
         CLASS_THREE: v = 21'h000800;
         default:     v = 21'h010000;
      endcase
      return v;
   endfunction

   // C0 controls and DEL through the C1 controls
   function automatic logic is_control(input logic [20:0] cp);
      return (cp <= 21'h00001F) || (cp >= 21'h00007F && cp <= 21'h00009F);
   endfunction

endpackage

`default_nettype wire

>>> rtl/utf8_validator_no_controls.sv
// Top level of the streaming strict UTF-8 validator with control rejection.
`default_nettype none

// Takes one byte per cycle with a last-byte flag and returns exactly one result
// per byte: the completed code point (if any), the sticky first error of the
// string and an end-of-string marker. Sustained rate is one byte per clock;
// a byte's result is registered: it passes the input register, then the
// decode logic into the result register, before it is on the outputs. The
// decoder state is updated as each byte moves into the result register, so
// back-to-back bytes of the same sequence need no stall. Both channels stall
// only on rsp_ready low.
module utf8_validator_no_controls
   import u8v_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_last_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [20:0] rsp_cp_value,
   output      logic        rsp_point_ready,
   output      logic [1:0]  rsp_status,
   output      logic        rsp_string_done
);

   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          in_last_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;
   logic          rsp_valid_ff;
   logic          out_open;
   logic          in_open;
   logic          advance;

   // Pipeline flow control: each register refills when its contents move on
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_open;
   assign in_open   = !in_valid_ff || out_open;
   assign req_ready = in_open;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_open) begin
         in_valid_ff <= req_valid;
      end
      if (in_open && req_valid) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_last_byte;
      end
   end

   u8v_decode u_decode (
      .byte_value (in_byte_ff),
      .last_byte  (in_last_ff),
      .cur_state  (state_ff),
      .next_state (state_in),
      .result     (rsp_in)
   );

   // Decoder state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (out_open) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cp_value    = rsp_ff.cp_value;
   assign rsp_point_ready = rsp_ff.point_ready;
   assign rsp_status      = rsp_ff.status;
   assign rsp_string_done = rsp_ff.string_done;

   // A code point is only emitted while the string is still clean
   a_point_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.point_ready |-> rsp_ff.status == ST_NONE)
      else $error("code point emitted with an error status");

   // Without a completed code point the value field is zero
   a_point_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.point_ready |-> rsp_ff.cp_value == 21'd0)
      else $error("code point nonzero without point_ready");

   // An open sequence never coexists with a recorded error
   a_pending_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_pending != 2'd0 |-> state_ff.first_error == ST_NONE)
      else $error("bytes pending after an error");

   // The last byte of a string leaves the decoder in its reset state
   a_string_reset: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff == SEQ_RESET)
      else $error("state not cleared at end of string");

   // The result register only loads when the input register delivers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !in_valid_ff |=> !rsp_valid_ff)
      else $error("result appeared without an input transfer");

endmodule

`default_nettype wire

>>> rtl/u8v_decode.sv
// Next-state and result logic for one byte of the UTF-8 validator.
`default_nettype none

module u8v_decode
   import u8v_pkg::*;
(
   input  wire logic [7:0]    byte_value,
   input  wire logic          last_byte,
   input  wire seq_state_type cur_state,
   output seq_state_type      next_state,
   output rsp_type            result
);

   seq_state_type upd;
   logic [20:0]   cp_new;
   logic [20:0]   cp_out;
   logic          ready;

   // Code point after appending this byte's six payload bits
   assign cp_new = {cur_state.partial_point[14:0], byte_value[5:0]};

   always_comb begin
      upd    = cur_state;
      cp_out = '0;
      ready  = 1'b0;
      if (cur_state.first_error == ST_NONE) begin
         if (cur_state.bytes_pending == 2'd0) begin
            // Lead byte or single-byte code point
            if (byte_value inside {[8'h00:8'h7F]}) begin
               if (is_control({13'd0, byte_value})) begin
                  upd.first_error = ST_CONTROL;
               end else begin
                  cp_out = {13'd0, byte_value};
                  ready  = 1'b1;
               end
            end else if (byte_value inside {[8'hC2:8'hDF]}) begin
               upd.bytes_pending   = 2'd1;
               upd.partial_point   = {16'd0, byte_value[4:0]};
               upd.min_point_class = CLASS_TWO;
            end else if (byte_value inside {[8'hE0:8'hEF]}) begin
               upd.bytes_pending   = 2'd2;
               upd.partial_point   = {17'd0, byte_value[3:0]};
               upd.min_point_class = CLASS_THREE;
            end else if (byte_value inside {[8'hF0:8'hF4]}) begin
               upd.bytes_pending   = 2'd3;
               upd.partial_point   = {18'd0, byte_value[2:0]};
               upd.min_point_class = CLASS_FOUR;
            end else begin
               upd.first_error = ST_MALFORMED;
            end
         end else if (byte_value[7:6] != 2'b10) begin
            // Expected a continuation byte
            upd             = SEQ_RESET;
            upd.first_error = ST_MALFORMED;
         end else begin
            upd.partial_point = cp_new;
            upd.bytes_pending = cur_state.bytes_pending - 2'd1;
            if (cur_state.bytes_pending == 2'd1) begin
               // Sequence complete: range checks, then control check
               if (cp_new < min_point(cur_state.min_point_class) ||
                   (cp_new >= SURR_LO && cp_new <= SURR_HI) || cp_new > CP_MAX) begin
                  upd.first_error = ST_MALFORMED;
               end else if (is_control(cp_new)) begin
                  upd.first_error = ST_CONTROL;
               end else begin
                  cp_out = cp_new;
                  ready  = 1'b1;
               end
               upd.bytes_pending   = 2'd0;
               upd.partial_point   = '0;
               upd.min_point_class = CLASS_TWO;
            end
         end
         // String ends inside a sequence
         if (last_byte && upd.bytes_pending != 2'd0 && upd.first_error == ST_NONE) begin
            upd.first_error = ST_MALFORMED;
         end
      end
   end

   assign result.cp_value    = cp_out;
   assign result.point_ready = ready;
   assign result.status      = upd.first_error;
   assign result.string_done = last_byte;

   // A finished string returns everything to its reset value
   assign next_state = last_byte ? SEQ_RESET : upd;

endmodule

`default_nettype wire

>>> test/utf8_validator_no_controls_tb.sv
// Self-checking testbench for the streaming UTF-8 validator with control rejection.
module utf8_validator_no_controls_tb;
   import u8v_pkg::*;

   localparam int unsigned RANDOM_BYTES = 1600;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   // One byte of a string waiting to be driven
   typedef struct {
      logic [7:0] value;
      logic       last;
      logic       hold;   // wait for all results before sending this byte
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_byte_value = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [20:0] rsp_cp_value;
   logic        rsp_point_ready;
   logic [1:0]  rsp_status;
   logic        rsp_string_done;

   byte_item_type pending_bytes[$];
   rsp_type       expected_results[$];
   logic [7:0]    str_buf[$];

   // Decoder state mirrored in the testbench
   logic [1:0]  cont_left = 2'd0;
   logic [20:0] gathered = 21'd0;
   logic [1:0]  seq_class = CLASS_TWO;
   logic [1:0]  sticky_status = ST_NONE;

   int unsigned xfer_cnt = 0;
   int unsigned sent_cnt = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned err_cnt = 0;
   int unsigned cycle_cnt = 0;
   int unsigned total_bytes = 0;
   logic        send_burst = 1'b0;
   logic        recv_burst = 1'b0;
   logic        rsp_took = 1'b0;
   byte_item_type cur;
   rsp_type     want;

   utf8_validator_no_controls u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_byte_value  (req_byte_value),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cp_value    (rsp_cp_value),
      .rsp_point_ready (rsp_point_ready),
      .rsp_status      (rsp_status),
      .rsp_string_done (rsp_string_done)
   );

   always #2 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // C0 controls, DEL and C1 controls
   function automatic logic in_control_range(input logic [20:0] cp);
      return (cp <= 21'h1F) || (cp >= 21'h7F && cp <= 21'h9F);
   endfunction

   // Clear the open sequence
   function automatic void drop_sequence();
      cont_left = 2'd0;
      gathered  = 21'd0;
      seq_class = CLASS_TWO;
   endfunction

   // Advance the mirrored decoder by one byte and return the result it yields
   function automatic rsp_type decode_byte(input logic [7:0] b, input logic last);
      rsp_type     r;
      logic [20:0] floor_cp;
      r = '0;
      if (sticky_status == ST_NONE) begin
         if (cont_left == 2'd0) begin
            if (b <= 8'h7F) begin
               if (in_control_range({13'd0, b})) begin
                  sticky_status = ST_CONTROL;
               end else begin
                  r.cp_value    = {13'd0, b};
                  r.point_ready = 1'b1;
               end
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
               cont_left = 2'd1;
               gathered  = {16'd0, b[4:0]};
               seq_class = CLASS_TWO;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
               cont_left = 2'd2;
               gathered  = {17'd0, b[3:0]};
               seq_class = CLASS_THREE;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
               cont_left = 2'd3;
               gathered  = {18'd0, b[2:0]};
               seq_class = CLASS_FOUR;
            end else begin
               sticky_status = ST_MALFORMED;
            end
         end else if (b[7:6] != 2'b10) begin
            sticky_status = ST_MALFORMED;
            drop_sequence();
         end else begin
            gathered  = {gathered[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
               case (seq_class)
                  CLASS_TWO:   floor_cp = 21'h80;
                  CLASS_THREE: floor_cp = 21'h800;
                  default:     floor_cp = 21'h10000;
               endcase
               // overlong, surrogate or beyond the last plane
               if (gathered < floor_cp || (gathered >= SURR_LO && gathered <= SURR_HI) ||
                   gathered > CP_MAX) begin
                  sticky_status = ST_MALFORMED;
               end else if (in_control_range(gathered)) begin
                  sticky_status = ST_CONTROL;
               end else begin
                  r.cp_value    = gathered;
                  r.point_ready = 1'b1;
               end
               drop_sequence();
            end
         end
         // string ends inside a sequence
         if (last && cont_left != 2'd0 && sticky_status == ST_NONE) begin
            sticky_status = ST_MALFORMED;
         end
      end
      r.status      = sticky_status;
      r.string_done = last;
      if (last) begin
         drop_sequence();
         sticky_status = ST_NONE;
      end
      return r;
   endfunction

   // Append one byte to the string being built
   task automatic add_byte(input logic [7:0] b);
      str_buf.insert(str_buf.size(), b);
   endtask

   // Encode a code point in n bytes; lengths larger than needed give overlong forms
   task automatic put_cp(input logic [20:0] cp, input int n);
      case (n)
         1: add_byte({1'b0, cp[6:0]});
         2: begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end
         3: begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
         default: begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // Legal code point that needs exactly n bytes (n = 2..4)
   function automatic logic [20:0] legal_point(input int n);
      logic [20:0] cp;
      case (n)
         2: cp = 21'($urandom_range(21'hA0, 21'h7FF));
         3: begin
            cp = 21'($urandom_range(21'h800, 21'hFFFF));
            if (cp >= SURR_LO && cp <= SURR_HI) cp = cp - 21'h800;
         end
         default: cp = 21'($urandom_range(21'h10000, CP_MAX));
      endcase
      return cp;
   endfunction

   // Move the gathered string into the send queue, flag on its final byte
   task automatic flush_string(input logic hold);
      for (int i = 0; i < str_buf.size(); i++) begin
         pending_bytes.insert(pending_bytes.size(),
                              '{str_buf[i], i == str_buf.size() - 1, hold && i == 0});
      end
      str_buf.delete();
   endtask

   // One code point of random kind, mostly well formed
   task automatic add_random_point();
      int          r;
      int          n;
      int          keep;
      int          idx;
      logic [7:0]  b;
      r = $urandom_range(0, 99);
      n = $urandom_range(2, 4);
      if (r < 30) begin
         put_cp(21'($urandom_range(21'h20, 21'h7E)), 1);
      end else if (r < 45) begin
         put_cp(legal_point(2), 2);
      end else if (r < 60) begin
         put_cp(legal_point(3), 3);
      end else if (r < 72) begin
         put_cp(legal_point(4), 4);
      end else if (r < 77) begin
         // control code points, one and two byte forms
         case ($urandom_range(0, 2))
            0: put_cp(21'($urandom_range(0, 21'h1F)), 1);
            1: put_cp(21'h7F, 1);
            default: put_cp(21'($urandom_range(21'h80, 21'h9F)), 2);
         endcase
      end else if (r < 81) begin
         // overlong
         put_cp(21'($urandom_range(0, n == 2 ? 21'h7F : (n == 3 ? 21'h7FF : 21'hFFFF))), n);
      end else if (r < 84) begin
         put_cp(21'($urandom_range(SURR_LO, SURR_HI)), 3);
      end else if (r < 87) begin
         put_cp(21'($urandom_range(CP_MAX + 21'd1, 21'h1FFFFF)), 4);
      end else if (r < 92) begin
         add_byte(8'($urandom_range(0, 255)));
      end else if (r < 96) begin
         // truncated sequence
         put_cp(legal_point(n), n);
         keep = $urandom_range(1, n - 1);
         repeat (n - keep) void'(str_buf.pop_back());
      end else begin
         // non-continuation byte inside a sequence
         put_cp(legal_point(n), n);
         idx = str_buf.size() - $urandom_range(1, n - 1);
         b = 8'($urandom_range(0, 255));
         if (b[7:6] == 2'b10) b[6] = 1'b1;
         str_buf[idx] = b;
      end
   endtask

   // Stimulus and end of run
   initial begin
      int unsigned target;
      int          cnt;
      logic        first;
      // ASCII, two-byte form and a C0 control
      put_cp(21'h41, 1); put_cp(21'hA0, 2); put_cp(21'h00, 1); flush_string(1'b0);
      put_cp(21'h9F, 2); flush_string(1'b0);   // C1 control
      put_cp(21'h7F, 1); flush_string(1'b0);   // DEL
      add_byte(8'hFF); put_cp(21'h41, 1); flush_string(1'b0);
      put_cp(21'h000, 3); flush_string(1'b0);  // overlong three-byte
      put_cp(SURR_LO, 3); flush_string(1'b0);
      put_cp(CP_MAX, 4); put_cp(CP_MAX + 21'd1, 4); flush_string(1'b0);
      add_byte(8'hE2); add_byte(8'h82); flush_string(1'b0);
      add_byte(8'hC3); add_byte(8'h41); flush_string(1'b0);

      target = pending_bytes.size() + RANDOM_BYTES;
      first = 1'b1;
      while (pending_bytes.size() < target) begin
         cnt = $urandom_range(1, 8);
         repeat (cnt) add_random_point();
         flush_string(first || $urandom_range(0, 299) == 0);
         first = 1'b0;
      end
      total_bytes = pending_bytes.size();

      while (!(xfer_cnt == total_bytes && expected_results.size() == 0)) @(posedge clock);
      repeat (10) @(posedge clock);
      if (err_cnt == 0) begin
         $display("utf8_validator_no_controls_tb: done, clean");
      end else begin
         $display("utf8_validator_no_controls_tb: done, errors");
      end
      $finish;
   end

   // Byte driver: gap per byte, optional hold until all results are back
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && xfer_cnt != sent_cnt)) begin
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() == 0 ||
                      (pending_bytes[0].hold && expected_results.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            cur = pending_bytes.pop_front();
            req_byte_value <= cur.value;
            req_last_byte  <= cur.last;
            req_valid      <= 1'b1;
            sent_cnt = sent_cnt + 1;
            if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
            gap_left = send_burst ? 0 : $urandom_range(0, 7);
         end
      end
   end

   // Result side back-pressure: new stall drawn after each transfer
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
            stall_left = recv_burst ? 0 : $urandom_range(0, 7);
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: check result transfers, predict on byte transfers
   always @(posedge clock) begin
      if (reset) begin
         rsp_took <= 1'b0;
      end else begin
         rsp_took <= rsp_valid && rsp_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result with no byte outstanding: cp_value %0h status %0d",
                      rsp_cp_value, rsp_status);
               err_cnt = err_cnt + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_cp_value !== want.cp_value) begin
                  $error("cp_value: expected %0h, got %0h", want.cp_value, rsp_cp_value);
                  err_cnt = err_cnt + 1;
               end
               if (rsp_point_ready !== want.point_ready) begin
                  $error("point_ready: expected %0d, got %0d", want.point_ready,
                         rsp_point_ready);
                  err_cnt = err_cnt + 1;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  err_cnt = err_cnt + 1;
               end
               if (rsp_string_done !== want.string_done) begin
                  $error("string_done: expected %0d, got %0d", want.string_done,
                         rsp_string_done);
                  err_cnt = err_cnt + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_results.insert(expected_results.size(),
                                    decode_byte(req_byte_value, req_last_byte));
            xfer_cnt <= xfer_cnt + 1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("utf8_validator_no_controls_tb: done, errors");
         $finish;
      end
   end

endmodule

>>> sim.f
rtl/u8v_pkg.sv
rtl/u8v_decode.sv
rtl/utf8_validator_no_controls.sv
test/utf8_validator_no_controls_tb.sv
